### hw/rtl/sact_pkg.sv
`default_nettype none

package sact_pkg;

    localparam int ANGLE_W   = 14;
    localparam int TURN_W    = 32;
    localparam int POS_W     = TURN_W + ANGLE_W;
    localparam int FRAME_W   = 24;
    localparam int CRC_W     = 6;
    localparam int RAW_W     = 32;

    // x^6 + x + 1, the x^6 term is implied by the shift out of the top bit
    localparam logic [CRC_W-1:0]   CRC6_POLY    = 6'h03;
    localparam logic [CRC_W-1:0]   CRC6_INIT    = 6'h00;
    // 0.8 of a 16384-count turn is 13107.2; a step of 13108 or more wraps
    localparam logic [ANGLE_W-1:0] UNWRAP_LIMIT = 14'd13107;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               bad;
    } t_frame_info;

    // Fold one 6-bit chunk into the running CRC, MSB first.
    function automatic logic [CRC_W-1:0] crc6_chunk(
        input logic [CRC_W-1:0] crc_in,
        input logic [CRC_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < CRC_W; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC6_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sact_frame_decode.sv
`default_nettype none

module sact_frame_decode #(
    parameter int DATA_SHIFT = 1
) (
    input  wire logic [sact_pkg::RAW_W-1:0] i_raw_word,
    input  wire logic                       i_crc_check_enable,
    output sact_pkg::t_frame_info           o_info
);

    logic [sact_pkg::FRAME_W-1:0] frame;
    logic [sact_pkg::CRC_W-1:0]   crc_a;
    logic [sact_pkg::CRC_W-1:0]   crc_b;
    logic [sact_pkg::CRC_W-1:0]   crc_calc;

    // shift left by DATA_SHIFT, then right by 8: a 24-bit window of the word
    assign frame = i_raw_word[8-DATA_SHIFT +: sact_pkg::FRAME_W];

    assign crc_a    = sact_pkg::crc6_chunk(sact_pkg::CRC6_INIT, frame[23:18]);
    assign crc_b    = sact_pkg::crc6_chunk(crc_a, frame[17:12]);
    assign crc_calc = sact_pkg::crc6_chunk(crc_b, frame[11:6]);

    assign o_info.angle = frame[23:10];
    assign o_info.bad   = i_crc_check_enable && (crc_calc != frame[5:0]);

endmodule

`default_nettype wire

### hw/rtl/sact_turn_unwrap.sv
`default_nettype none

module sact_turn_unwrap (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_upd,
    input  wire sact_pkg::t_frame_info         i_info,
    output logic [sact_pkg::ANGLE_W-1:0]       o_next_angle,
    output logic [sact_pkg::TURN_W-1:0]        o_next_turns
);

    logic [sact_pkg::ANGLE_W-1:0] r_last_angle;
    logic [sact_pkg::TURN_W-1:0]  r_turns;
    logic                         r_seeded;
    logic [sact_pkg::ANGLE_W-1:0] n_last_angle;
    logic [sact_pkg::TURN_W-1:0]  n_turns;
    logic                         n_seeded;
    logic                         up;
    logic [sact_pkg::ANGLE_W-1:0] diff;
    logic                         wrap;

    assign up   = i_info.angle > r_last_angle;
    assign diff = up ? (i_info.angle - r_last_angle) : (r_last_angle - i_info.angle);
    assign wrap = diff > sact_pkg::UNWRAP_LIMIT;

    always_comb begin
        n_last_angle = r_last_angle;
        n_turns      = r_turns;
        n_seeded     = r_seeded;
        if (i_upd && !i_info.bad) begin
            // a jump of most of a turn is a wrap the other way
            if (r_seeded && wrap) begin
                n_turns = up ? (r_turns - 32'd1) : (r_turns + 32'd1);
            end
            n_last_angle = i_info.angle;
            n_seeded     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_turns      <= '0;
            r_seeded     <= 1'b0;
        end else begin
            r_last_angle <= n_last_angle;
            r_turns      <= n_turns;
            r_seeded     <= n_seeded;
        end
    end

    assign o_next_angle = n_last_angle;
    assign o_next_turns = n_turns;

    a_bad_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && i_info.bad |=> $stable(r_last_angle) && $stable(r_turns)
                                && $stable(r_seeded))
        else $error("bad frame changed tracker state");

    a_turn_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_turns == $past(r_turns)) || (r_turns == $past(r_turns) + 32'd1)
                 || (r_turns == $past(r_turns) - 32'd1))
        else $error("turn counter moved by more than one");

    a_seed_keeps_turns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && !i_info.bad && !r_seeded |=> r_seeded && $stable(r_turns))
        else $error("first good frame changed the turn counter");

    a_idle_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd |=> $stable(r_last_angle) && $stable(r_turns))
        else $error("tracker state changed without an update");

endmodule

`default_nettype wire

### hw/rtl/ssi_angle_crc_turn_tracker_top.sv
`default_nettype none

// SSI angle tracker: each request carries one raw 32-bit sensor word. The word
// is shifted left by DATA_SHIFT and right by 8 to form a 24-bit frame holding
// a 14-bit angle (bits 23..10) and a CRC6 (bits 5..0, x^6+x+1, init 0, over
// bits 23..6). A frame that passes, or any frame while i_cfg_wr_data was last
// written as 0, unwraps the angle into a signed 32-bit turn count; a jump of
// more than 0.8 of a turn moves the count one step the opposite way, and the
// first passing frame after reset only seeds the tracker. A failing frame sets
// o_crc_error and leaves the tracker alone. Every request yields exactly one
// result: the stored angle, turn count and 46-bit position (turns * 16384 +
// angle) after that request. The block takes one request per cycle unless the
// result stalls; a request passes from the input register to the result
// register, with the decode, CRC and unwrap done in the single combinational
// step between them. A stalled result holds the result register and the input
// register takes one more request before o_ready drops. The CRC check is
// enabled out of reset; write the enable only while no request is in flight.
module ssi_angle_crc_turn_tracker_top #(
    parameter int DATA_SHIFT = 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_wr_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [sact_pkg::RAW_W-1:0]         i_raw_word,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [sact_pkg::ANGLE_W-1:0]            o_angle_counts,
    output logic signed [sact_pkg::TURN_W-1:0]      o_turn_count,
    output logic signed [sact_pkg::POS_W-1:0]       o_position_counts,
    output logic                                    o_crc_error
);

    // Configuration: CRC check enable, on after reset.
    logic r_crc_check_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_check_enable <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_crc_check_enable <= i_cfg_wr_data;
        end
    end

    // Input register: hold the raw word until the result register is free.
    logic                       r_in_vld;
    logic [sact_pkg::RAW_W-1:0] r_in_word;
    logic                       r_out_vld;
    logic                       adv;

    // advance when the result register is empty or being drained this cycle
    assign adv     = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_word <= i_raw_word;
        end
    end

    // Decode the frame and check its CRC.
    sact_pkg::t_frame_info frame_info;

    sact_frame_decode #(
        .DATA_SHIFT(DATA_SHIFT)
    ) u_decode (
        .i_raw_word        (r_in_word),
        .i_crc_check_enable(r_crc_check_enable),
        .o_info            (frame_info)
    );

    // Unwrap into turns; state moves only when the request leaves the input
    // register for the result register.
    logic                          upd;
    logic [sact_pkg::ANGLE_W-1:0]  next_angle;
    logic [sact_pkg::TURN_W-1:0]   next_turns;

    assign upd = r_in_vld && adv;

    sact_turn_unwrap u_unwrap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (upd),
        .i_info      (frame_info),
        .o_next_angle(next_angle),
        .o_next_turns(next_turns)
    );

    // Result register: hold the result until the consumer takes it.
    logic [sact_pkg::ANGLE_W-1:0]  r_out_angle;
    logic [sact_pkg::TURN_W-1:0]   r_out_turns;
    logic                          r_out_crc_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_out_angle     <= next_angle;
            r_out_turns     <= next_turns;
            r_out_crc_error <= frame_info.bad;
        end
    end

    // angle is below one turn, so the position is the plain concatenation
    assign o_valid           = r_out_vld;
    assign o_angle_counts    = r_out_angle;
    assign o_turn_count      = r_out_turns;
    assign o_position_counts = {r_out_turns, r_out_angle};
    assign o_crc_error       = r_out_crc_error;

endmodule

`default_nettype wire
